>>> hw/rtl/ifwt_pkg.sv
// shared types, codes and reset values for the in-flight frame window tracker
`timescale 1ns / 1ps
package ifwt_pkg;

    localparam int DEF_MAX_PENDING = 32;

    localparam int KIND_W  = 2;
    localparam int ID_W    = 32;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 6;
    localparam int THR_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_CNT_W  = 6;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUBMIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RTT_MID_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RTT_HIGH_THR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUT  = 3'd5;

    // register reset values
    localparam logic [WIN_W-1:0] RST_WINDOW_BASE  = 6'd16;
    localparam logic [WIN_W-1:0] RST_WINDOW_MID   = 6'd20;
    localparam logic [WIN_W-1:0] RST_WINDOW_HIGH  = 6'd24;
    localparam logic [THR_W-1:0] RST_RTT_MID_THR  = 16'd50;
    localparam logic [THR_W-1:0] RST_RTT_HIGH_THR = 16'd100;
    localparam logic [THR_W-1:0] RST_MIN_TIMEOUT  = 16'd120;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] sent;
    } t_entry;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

>>> hw/rtl/ifwt_cell.sv
// one slot of the pending-frame chain: loads a new entry or takes its neighbour's
`timescale 1ns / 1ps
module ifwt_cell (
    input  logic              i_clk,
    input  ifwt_pkg::t_cell_ctl i_ctl,
    input  ifwt_pkg::t_entry  i_next,
    input  ifwt_pkg::t_entry  i_new,
    output ifwt_pkg::t_entry  o_entry
);
    import ifwt_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hw/rtl/inflight_frame_window_tracker_core.sv
// top level: sequencer, configuration registers and the chain of pending-frame cells
`timescale 1ns / 1ps
// Tracks sent but unacknowledged frames in a chain of MAX_PENDING cells, the
// oldest frame always in the first cell. One word in gives one word out. A tick,
// a submit or an unused kind passes through the exec and done states; an ack goes
// from exec to the pop state, which drops one entry from the chain's head each
// cycle while the head id is at most the acked one, and then on to done. The
// next word is taken once the result is offered, never while one is in progress.
// A result held back by the receiver stalls the following word in its done state
// until the output register is free. A new word is taken while a finished result
// still waits at the output. Configuration is to be written through the plain
// write port only while the block is idle; the block itself does not enforce this.
module inflight_frame_window_tracker_core #(
    parameter int MAX_PENDING = ifwt_pkg::DEF_MAX_PENDING
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ifwt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [31:0] ack_frame_id
    input  logic [ifwt_pkg::KIND_W-1:0]       s_axis_tuser,  // [1:0] kind
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] granted, [32:1] assigned_frame_id, [33] window_flushed,
    // [65:34] measured_rtt_ms, [71:66] pending_count
    output logic [ifwt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [ifwt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ifwt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ifwt_pkg::*;

    localparam int CW = $clog2(MAX_PENDING + 1);
    localparam int IW = $clog2(MAX_PENDING);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PENDING);

    t_state r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [ID_W-1:0]   r_ack, n_ack;
    logic [CW-1:0]     r_count, n_count;
    logic [TIME_W-1:0] r_clock, n_clock;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [TIME_W-1:0] r_last_rtt, n_last_rtt;

    logic              r_granted, n_granted;
    logic [ID_W-1:0]   r_assigned, n_assigned;
    logic              r_flushed, n_flushed;
    logic [TIME_W-1:0] r_rtt, n_rtt;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic [WIN_W-1:0] r_win_base, r_win_mid, r_win_high;
    logic [THR_W-1:0] r_rtt_mid_thr, r_rtt_high_thr, r_min_timeout;

    // chain wiring
    t_entry    w_cell_q   [MAX_PENDING];
    t_entry    w_cell_nxt [MAX_PENDING];
    t_cell_ctl w_cell_ctl [MAX_PENDING];
    t_entry    w_new_entry;

    logic [WIN_W-1:0]  w_window;
    logic              w_room;
    logic [TIME_W-1:0] w_age;
    logic [TIME_W:0]   w_timeout;
    logic              w_stale;
    logic              w_flush;
    logic              w_admit;
    logic [CW-1:0]     w_base_count;
    logic              w_write;
    logic [IW-1:0]     w_wr_idx;
    logic              w_pop;
    logic              w_out_free;

    assign w_new_entry = '{id: r_next_id, sent: r_clock};

    // window chosen from the last rtt, high threshold tested first
    always_comb begin
        if (r_last_rtt > TIME_W'(r_rtt_high_thr)) begin
            w_window = r_win_high;
        end else if (r_last_rtt > TIME_W'(r_rtt_mid_thr)) begin
            w_window = r_win_mid;
        end else begin
            w_window = r_win_base;
        end
    end

    // saturating the window at the store size is the same as also needing count < size
    assign w_room = (TIME_W'(r_count) < TIME_W'(w_window)) && (r_count < MAX_CNT);

    assign w_age = r_clock - w_cell_q[0].sent;

    always_comb begin
        if ({r_last_rtt, 1'b0} < (TIME_W + 1)'(r_min_timeout)) begin
            w_timeout = (TIME_W + 1)'(r_min_timeout);
        end else begin
            w_timeout = {r_last_rtt, 1'b0};
        end
    end

    assign w_stale = {1'b0, w_age} > w_timeout;

    assign w_flush      = !w_room && (r_count != '0) && w_stale;
    assign w_admit      = w_room || w_flush;
    assign w_base_count = w_flush ? '0 : r_count;
    assign w_write      = (r_state == S_EXEC) && (r_kind == KIND_SUBMIT)
                          && w_admit && (w_base_count < MAX_CNT);
    assign w_wr_idx     = w_base_count[IW-1:0];

    assign w_pop = (r_state == S_POP) && (r_count != '0) && (w_cell_q[0].id <= r_ack);

    assign w_out_free = !r_out_valid || m_axis_tready;

    genvar g;
    generate
        for (g = 0; g < MAX_PENDING; g++) begin : g_cell
            if (g == MAX_PENDING - 1) begin : g_last
                assign w_cell_nxt[g] = w_cell_q[g];
            end else begin : g_mid
                assign w_cell_nxt[g] = w_cell_q[g + 1];
            end

            assign w_cell_ctl[g].shift = w_pop;
            assign w_cell_ctl[g].load  = w_write && (w_wr_idx == IW'(g));

            ifwt_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_cell_ctl[g]),
                .i_next  (w_cell_nxt[g]),
                .i_new   (w_new_entry),
                .o_entry (w_cell_q[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_ack       = r_ack;
        n_count     = r_count;
        n_clock     = r_clock;
        n_next_id   = r_next_id;
        n_last_rtt  = r_last_rtt;
        n_granted   = r_granted;
        n_assigned  = r_assigned;
        n_flushed   = r_flushed;
        n_rtt       = r_rtt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind     = s_axis_tuser;
                    n_ack      = s_axis_tdata[ID_W-1:0];
                    n_granted  = 1'b0;
                    n_assigned = '0;
                    n_flushed  = 1'b0;
                    n_rtt      = '0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_kind)
                    KIND_TICK: begin
                        n_clock = r_clock + 1'b1;
                    end
                    KIND_SUBMIT: begin
                        n_flushed = w_flush;
                        n_count   = w_base_count;
                        if (w_write) begin
                            n_count    = w_base_count + 1'b1;
                            n_granted  = 1'b1;
                            n_assigned = r_next_id;
                            n_next_id  = r_next_id + 1'b1;
                        end
                    end
                    KIND_ACK: begin
                        n_state = S_POP;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_POP: begin
                if (w_pop) begin
                    n_count    = r_count - 1'b1;
                    n_rtt      = w_age;
                    n_last_rtt = w_age;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {OUT_CNT_W'(r_count), r_rtt, r_flushed, r_assigned, r_granted};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_clock     <= '0;
            r_next_id   <= '0;
            r_last_rtt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clock     <= n_clock;
            r_next_id   <= n_next_id;
            r_last_rtt  <= n_last_rtt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_ack      <= n_ack;
        r_granted  <= n_granted;
        r_assigned <= n_assigned;
        r_flushed  <= n_flushed;
        r_rtt      <= n_rtt;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_base     <= RST_WINDOW_BASE;
            r_win_mid      <= RST_WINDOW_MID;
            r_win_high     <= RST_WINDOW_HIGH;
            r_rtt_mid_thr  <= RST_RTT_MID_THR;
            r_rtt_high_thr <= RST_RTT_HIGH_THR;
            r_min_timeout  <= RST_MIN_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_WINDOW_BASE:  r_win_base     <= i_cfg_data[WIN_W-1:0];
                REG_WINDOW_MID:   r_win_mid      <= i_cfg_data[WIN_W-1:0];
                REG_WINDOW_HIGH:  r_win_high     <= i_cfg_data[WIN_W-1:0];
                REG_RTT_MID_THR:  r_rtt_mid_thr  <= i_cfg_data[THR_W-1:0];
                REG_RTT_HIGH_THR: r_rtt_high_thr <= i_cfg_data[THR_W-1:0];
                REG_MIN_TIMEOUT:  r_min_timeout  <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> sim/testbench.sv
// self-checking testbench for the in-flight frame window tracker core
`timescale 1ns / 1ps
import ifwt_pkg::*;

typedef struct {
    logic                 granted;
    logic [ID_W-1:0]      assigned;
    logic                 flushed;
    logic [TIME_W-1:0]    rtt;
    logic [OUT_CNT_W-1:0] count;
} t_tracker_status;

class window_scoreboard;
    // tracker state as the block should hold it
    logic [ID_W-1:0]   pend_id   [DEF_MAX_PENDING];
    logic [TIME_W-1:0] pend_sent [DEF_MAX_PENDING];
    int unsigned       head_ix;
    int unsigned       tail_ix;
    int unsigned       fill;
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   next_id;
    logic [TIME_W-1:0] last_rtt;

    logic [WIN_W-1:0]  win_base;
    logic [WIN_W-1:0]  win_mid;
    logic [WIN_W-1:0]  win_high;
    logic [THR_W-1:0]  thr_mid;
    logic [THR_W-1:0]  thr_high;
    logic [THR_W-1:0]  min_to;

    t_tracker_status   awaited[$];
    int                fails;
    int                checked;

    function new();
        head_ix  = 0;
        tail_ix  = 0;
        fill     = 0;
        now_ms   = '0;
        next_id  = '0;
        last_rtt = '0;
        win_base = RST_WINDOW_BASE;
        win_mid  = RST_WINDOW_MID;
        win_high = RST_WINDOW_HIGH;
        thr_mid  = RST_RTT_MID_THR;
        thr_high = RST_RTT_HIGH_THR;
        min_to   = RST_MIN_TIMEOUT;
        fails    = 0;
        checked  = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_BASE:  win_base = data[WIN_W-1:0];
            REG_WINDOW_MID:   win_mid  = data[WIN_W-1:0];
            REG_WINDOW_HIGH:  win_high = data[WIN_W-1:0];
            REG_RTT_MID_THR:  thr_mid  = data[THR_W-1:0];
            REG_RTT_HIGH_THR: thr_high = data[THR_W-1:0];
            REG_MIN_TIMEOUT:  min_to   = data[THR_W-1:0];
            default: ;
        endcase
    endfunction

    // window picked from the last rtt, capped at the store size
    function int unsigned admit_limit();
        int unsigned w;
        if (last_rtt > thr_high) begin
            w = win_high;
        end else if (last_rtt > thr_mid) begin
            w = win_mid;
        end else begin
            w = win_base;
        end
        return (w > DEF_MAX_PENDING) ? DEF_MAX_PENDING : w;
    endfunction

    function t_tracker_status track_word(logic [KIND_W-1:0] kind, logic [ID_W-1:0] ack);
        t_tracker_status st;
        bit              admit;
        logic [TIME_W:0] timeout;
        logic [TIME_W-1:0] age;
        st = '{granted: 1'b0, assigned: '0, flushed: 1'b0, rtt: '0, count: '0};
        case (kind)
            KIND_TICK: begin
                now_ms = now_ms + 1;
            end
            KIND_SUBMIT: begin
                admit = 1'b0;
                if (fill < admit_limit()) begin
                    admit = 1'b1;
                end else if (fill > 0) begin
                    timeout = {last_rtt, 1'b0};
                    age     = now_ms - pend_sent[head_ix];
                    if (timeout < {17'd0, min_to}) timeout = {17'd0, min_to};
                    // stale only when strictly older than the timeout
                    if ({1'b0, age} > timeout) begin
                        head_ix    = 0;
                        tail_ix    = 0;
                        fill       = 0;
                        st.flushed = 1'b1;
                        admit      = 1'b1;
                    end
                end
                if (admit && fill < DEF_MAX_PENDING) begin
                    st.assigned        = next_id;
                    pend_id[tail_ix]   = next_id;
                    pend_sent[tail_ix] = now_ms;
                    next_id            = next_id + 1;
                    tail_ix            = (tail_ix + 1) % DEF_MAX_PENDING;
                    fill++;
                    st.granted = 1'b1;
                end
            end
            KIND_ACK: begin
                // cumulative ack pops from the front until an id above the acked one
                while (fill > 0 && pend_id[head_ix] <= ack) begin
                    st.rtt   = now_ms - pend_sent[head_ix];
                    last_rtt = st.rtt;
                    head_ix  = (head_ix + 1) % DEF_MAX_PENDING;
                    fill--;
                end
            end
            default: ;
        endcase
        st.count = fill[OUT_CNT_W-1:0];
        return st;
    endfunction

    function void note_word(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data);
        awaited = {awaited, track_word(kind, data[ID_W-1:0])};
    endfunction

    task report(string what);
        fails++;
        if (fails <= 40) $display("mismatch on result %0d: %s", checked, what);
    endtask

    task check_word(logic [OUT_DATA_W-1:0] w);
        t_tracker_status want;
        t_tracker_status got;
        got.granted  = w[0];
        got.assigned = w[32:1];
        got.flushed  = w[33];
        got.rtt      = w[65:34];
        got.count    = w[71:66];
        checked++;
        if (awaited.size() == 0) begin
            report($sformatf("result word %h with nothing outstanding", w));
            return;
        end
        want = awaited[0];
        awaited.delete(0);
        if (got.granted !== want.granted)
            report($sformatf("granted %b, expected %b", got.granted, want.granted));
        if (got.assigned !== want.assigned)
            report($sformatf("frame id %h, expected %h", got.assigned, want.assigned));
        if (got.flushed !== want.flushed)
            report($sformatf("flushed %b, expected %b", got.flushed, want.flushed));
        if (got.rtt !== want.rtt)
            report($sformatf("rtt %0d, expected %0d", got.rtt, want.rtt));
        if (got.count !== want.count)
            report($sformatf("pending %0d, expected %0d", got.count, want.count));
    endtask
endclass

module testbench;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = DEF_MAX_PENDING + 8;
    localparam int HOLD_CYCLES   = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    bit hold_req = 1'b0;

    window_scoreboard sb;

    inflight_frame_window_tracker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // results checked before the new word is noted
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
        end
    end

    // receiver, with one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready = ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL inflight_frame_window_tracker_core");
        $finish;
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = word;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.load_reg(idx, data);
    endtask

    // window registers get junk above bit 5, which must be dropped
    task automatic apply_config(input logic [WIN_W-1:0] base, input logic [WIN_W-1:0] mid,
                                input logic [WIN_W-1:0] high, input logic [THR_W-1:0] thr_m,
                                input logic [THR_W-1:0] thr_h, input logic [THR_W-1:0] tmo);
        write_reg(REG_WINDOW_BASE, (16'($urandom()) & 16'hFFC0) | 16'(base));
        write_reg(REG_WINDOW_MID, (16'($urandom()) & 16'hFFC0) | 16'(mid));
        write_reg(REG_WINDOW_HIGH, (16'($urandom()) & 16'hFFC0) | 16'(high));
        write_reg(REG_RTT_MID_THR, thr_m);
        write_reg(REG_RTT_HIGH_THR, thr_h);
        write_reg(REG_MIN_TIMEOUT, tmo);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // mostly acks that land inside or just around the pending ids
    function automatic logic [ID_W-1:0] pick_ack();
        logic [ID_W-1:0] oldest;
        int              roll;
        roll   = $urandom_range(0, 99);
        oldest = sb.next_id - sb.fill;
        if (roll < 75) return oldest + $urandom_range(0, sb.fill + 1) - 1;
        if (roll < 88) return $urandom();
        if (roll < 94) return 32'hFFFF_FFFF;
        return 32'h0;
    endfunction

    task automatic run_random(input int n, input int burst_max);
        int              burst_left;
        int              roll;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0] word;
        burst_left = 0;
        for (int i = 0; i < n; i++) begin
            word = $urandom();
            if (burst_left > 0) begin
                kind = KIND_TICK;
                burst_left--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    // run of ticks to age the store
                    burst_left = $urandom_range(4, burst_max);
                    kind = KIND_TICK;
                end else if (roll < 33) begin
                    kind = KIND_TICK;
                end else if (roll < 72) begin
                    kind = KIND_SUBMIT;
                end else if (roll < 97) begin
                    kind = KIND_ACK;
                    word = pick_ack();
                end else begin
                    kind = KIND_UNUSED;
                end
            end
            send_word(kind, word);
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_TICK;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = REG_WINDOW_BASE;
        i_cfg_data    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct = 37;
        dst_idle_pct = 66;

        // directed: tight window, timeout of 2 ms
        apply_config(6'd2, 6'd3, 6'd4, 16'd1, 16'd3, 16'd2);
        send_word(KIND_TICK, 32'hFFFF_FFFF);
        send_word(KIND_ACK, 32'h0);              // nothing pending
        send_word(KIND_SUBMIT, 32'h5A5A_5A5A);
        send_word(KIND_SUBMIT, 32'h0);
        send_word(KIND_SUBMIT, 32'hFFFF_FFFF);   // full, fresh
        send_word(KIND_TICK, 32'h0);
        send_word(KIND_TICK, 32'h1234_5678);
        send_word(KIND_SUBMIT, 32'h0);           // age equals timeout, still refused
        send_word(KIND_TICK, 32'h0);
        send_word(KIND_SUBMIT, 32'h0);           // stale, flush and grant
        send_word(KIND_ACK, 32'h1);              // below the oldest id
        send_word(KIND_UNUSED, 32'hDEAD_BEEF);
        send_word(KIND_TICK, 32'h0);
        send_word(KIND_TICK, 32'h0);
        send_word(KIND_ACK, 32'hFFFF_FFFF);      // rtt of 2 moves to the mid window
        send_word(KIND_SUBMIT, 32'h0);
        send_word(KIND_SUBMIT, 32'h0);
        send_word(KIND_SUBMIT, 32'h0);
        send_word(KIND_SUBMIT, 32'h0);           // mid window full
        send_word(KIND_ACK, 32'd3);              // zero rtt, back to the base window
        send_word(KIND_SUBMIT, 32'h0);
        send_word(KIND_ACK, 32'd5);
        send_word(KIND_ACK, 32'h0);
        drain();

        apply_config(6'd4, 6'd6, 6'd8, 16'd2, 16'd6, 16'd10);
        run_random(220, 15);
        drain();

        // zero base window, oversized mid window, no timeout floor
        apply_config(6'd0, 6'd63, 6'd32, 16'd0, 16'hFFFF, 16'd0);
        run_random(220, 6);
        drain();

        src_idle_pct = 66;
        dst_idle_pct = 37;
        // full store size, never stale
        apply_config(6'd63, 6'd1, 6'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(200, 4);
        drain();

        apply_config(6'd1, 6'd2, 6'd3, 16'd1, 16'd3, 16'd1);
        run_random(220, 8);
        drain();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        apply_config(RST_WINDOW_BASE, RST_WINDOW_MID, RST_WINDOW_HIGH,
                     RST_RTT_MID_THR, RST_RTT_HIGH_THR, RST_MIN_TIMEOUT);
        run_random(300, 160);
        drain();

        // receiver holds off while words keep coming
        apply_config(6'd8, 6'd12, 6'd32, 16'd3, 16'd8, 16'd20);
        hold_req = 1'b1;
        run_random(200, 30);
        drain();

        if (sb.fails == 0 && sb.awaited.size() == 0) begin
            $display("PASS inflight_frame_window_tracker_core");
        end else begin
            $display("FAIL inflight_frame_window_tracker_core");
        end
        $finish;
    end

endmodule
